/* src/ucdp_pkg.sv */
package ucdp_pkg;

    localparam int EP_NUMBERS = 16;
    localparam int FIFO_DEPTH = 4;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_WALK   = 2'd2;

    localparam logic KIND_EP  = 1'b0;
    localparam logic KIND_END = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_CFG   = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_NO_IFACE  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;

    localparam logic [7:0] DT_CONFIG    = 8'd2;
    localparam logic [7:0] DT_INTERFACE = 8'd4;
    localparam logic [7:0] DT_ENDPOINT  = 8'd5;
    localparam logic [7:0] CFG_HDR_LEN  = 8'd9;
    localparam logic [7:0] DIR_IN_MASK  = 8'h80;
    localparam logic [1:0] XFER_CONTROL = 2'd0;

    localparam logic [0:0] REG_EP0_SIZE = 1'd0;

    typedef struct packed {
        logic        record_kind;
        logic [3:0]  iface_slot;
        logic [4:0]  ep_slot;
        logic [3:0]  ep_number;
        logic        ep_is_in;
        logic [1:0]  xfer_kind;
        logic [15:0] packet_limit;
        logic [15:0] table_in_now;
        logic [15:0] table_out_now;
        logic [4:0]  iface_total;
        logic [2:0]  status_code;
        logic        run_last;
    } rec_t;

endpackage

/* src/ucdp_in_if.sv */
interface ucdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_flag;

    modport source (output valid, output data_byte, output start_flag, input ready);
    modport sink (input valid, input data_byte, input start_flag, output ready);
endinterface

/* src/ucdp_out_if.sv */
interface ucdp_out_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [3:0]  iface_slot;
    logic [4:0]  ep_slot;
    logic [3:0]  ep_number;
    logic        ep_is_in;
    logic [1:0]  xfer_kind;
    logic [15:0] packet_limit;
    logic [15:0] table_in_now;
    logic [15:0] table_out_now;
    logic [4:0]  iface_total;
    logic [2:0]  status_code;
    logic        run_last;

    modport source (output valid, input ready, output record_kind, output iface_slot,
                    output ep_slot, output ep_number, output ep_is_in, output xfer_kind,
                    output packet_limit, output table_in_now, output table_out_now,
                    output iface_total, output status_code, output run_last);
    modport sink (input valid, output ready, input record_kind, input iface_slot,
                  input ep_slot, input ep_number, input ep_is_in, input xfer_kind,
                  input packet_limit, input table_in_now, input table_out_now,
                  input iface_total, input status_code, input run_last);
endinterface

/* src/usb_config_descriptor_parser.sv */
// USB configuration descriptor parser.
// in_ch carries one descriptor byte per request; start_flag marks byte 0 of a
// new buffer and aborts any parse in progress. out_ch carries endpoint records
// and one end record per parse not aborted, run_last on a byte's last record.
// The APB port holds ep0_packet_size at address 0, loaded into entry 0 of
// both max-packet tables on each start byte.
// Each accepted byte is parsed in the cycle it is taken; its records (up to
// two) are registered into a four-entry output queue and reach out_ch in order.
// Throughput is one byte per cycle while the queue has room for two records;
// in_ch.ready drops when the queue holds three or more, so a stalled receiver
// holds the input after at most three more bytes with results.
// Reset empties the queue, sets the parser idle, clears the tables with entry
// 0 at 64 and sets ep0_packet_size to 64. Bytes without start_flag while idle
// are dropped with no record.
module usb_config_descriptor_parser #(
    parameter int MAX_IFACES        = 16,
    parameter int MAX_EPS_PER_IFACE = 32,
    parameter int MAX_TOTAL_BYTES   = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    ucdp_in_if.sink     in_ch,
    ucdp_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IFC_W = $clog2(MAX_IFACES + 1);
    localparam int EPC_W = $clog2(MAX_EPS_PER_IFACE + 1);
    localparam int NUM_EP = ucdp_pkg::EP_NUMBERS;
    localparam int DEPTH = ucdp_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [6:0]  ep0_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] bi_reg, bi_next;
    logic [15:0] tot_reg, tot_next;
    logic [7:0]  off_reg, off_next;
    logic [7:0]  dlen_reg, dlen_next;
    logic [7:0]  dtype_reg, dtype_next;
    logic [7:0]  fb2_reg, fb2_next, fb3_reg, fb3_next;
    logic [7:0]  fb4_reg, fb4_next, fb5_reg, fb5_next;
    logic [7:0]  decl_reg, decl_next;
    logic [IFC_W-1:0] icnt_reg, icnt_next;
    logic [7:0]  cur_num_reg, cur_num_next;
    logic        cur_val_reg, cur_val_next;
    logic [7:0]  cur_eps_reg, cur_eps_next;
    logic [EPC_W-1:0] cur_epc_reg, cur_epc_next;
    logic [15:0] tin_reg [NUM_EP];
    logic [15:0] tout_reg [NUM_EP];

    ucdp_pkg::rec_t fifo_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic        acc, pop;
    logic [7:0]  b;
    logic [1:0]  n;
    ucdp_pkg::rec_t r0, r1;
    logic        tbl_clr, tbl_we;
    logic [3:0]  tnum;
    logic [15:0] tin_new, tout_new;

    logic [7:0]  dl_e, dt_e, f2_e, f3_e, f4_e, f5_e;
    logic [IFC_W-1:0] ifno;
    logic [15:0] wmp;
    logic        fin, ended;
    logic [17:0] nxt;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ucdp_pkg::REG_EP0_SIZE) ? {25'd0, ep0_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ep0_reg <= 7'd64;
        end
        else if (psel && penable && pwrite && paddr[2] == ucdp_pkg::REG_EP0_SIZE)
        begin
            ep0_reg <= pwdata[6:0];
        end
    end

    assign acc = in_ch.valid && in_ch.ready;
    assign b = in_ch.data_byte;
    assign in_ch.ready = (cnt_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        phase_next = phase_reg;
        bi_next = bi_reg;
        tot_next = tot_reg;
        off_next = off_reg;
        dlen_next = dlen_reg;
        dtype_next = dtype_reg;
        fb2_next = fb2_reg;
        fb3_next = fb3_reg;
        fb4_next = fb4_reg;
        fb5_next = fb5_reg;
        decl_next = decl_reg;
        icnt_next = icnt_reg;
        cur_num_next = cur_num_reg;
        cur_val_next = cur_val_reg;
        cur_eps_next = cur_eps_reg;
        cur_epc_next = cur_epc_reg;
        n = 2'd0;
        r0 = '0;
        r1 = '0;
        tbl_clr = 1'b0;
        tbl_we = 1'b0;
        tin_new = 16'd0;
        tout_new = 16'd0;
        ended = 1'b0;
        fin = 1'b0;
        nxt = 18'd0;
        ifno = icnt_reg - IFC_W'(1);
        dl_e = (off_reg == 8'd0) ? b : dlen_reg;
        dt_e = (off_reg == 8'd1) ? b : ((off_reg == 8'd0) ? 8'd0 : dtype_reg);
        f2_e = (off_reg == 8'd2) ? b : ((off_reg == 8'd0) ? 8'd0 : fb2_reg);
        f3_e = (off_reg == 8'd3) ? b : ((off_reg == 8'd0) ? 8'd0 : fb3_reg);
        f4_e = (off_reg == 8'd4) ? b : ((off_reg == 8'd0) ? 8'd0 : fb4_reg);
        f5_e = (off_reg == 8'd5) ? b : ((off_reg == 8'd0) ? 8'd0 : fb5_reg);
        wmp = {f5_e, f4_e};
        tnum = f2_e[3:0];

        if (acc && in_ch.start_flag)
        begin
            phase_next = ucdp_pkg::PH_HEADER;
            bi_next = 16'd0;
            tot_next = 16'd0;
            off_next = 8'd0;
            dlen_next = b;
            dtype_next = 8'd0;
            fb2_next = 8'd0;
            fb3_next = 8'd0;
            fb4_next = 8'd0;
            fb5_next = 8'd0;
            decl_next = 8'd0;
            icnt_next = '0;
            cur_val_next = 1'b0;
            cur_num_next = 8'd0;
            tbl_clr = 1'b1;
        end
        else if (acc && phase_reg != ucdp_pkg::PH_IDLE)
        begin
            bi_next = bi_reg + 16'd1;
            r0.record_kind = ucdp_pkg::KIND_END;
            r0.iface_total = 5'(icnt_reg);
            if (phase_reg == ucdp_pkg::PH_HEADER)
            begin
                case (bi_next)
                    16'd1:
                    begin
                        dtype_next = b;
                        if (b != ucdp_pkg::DT_CONFIG)
                        begin
                            ended = 1'b1;
                            r0.status_code = ucdp_pkg::ST_NOT_CFG;
                        end
                        else if (dlen_reg != ucdp_pkg::CFG_HDR_LEN)
                        begin
                            ended = 1'b1;
                            r0.status_code = ucdp_pkg::ST_BAD_LEN;
                        end
                    end
                    16'd2: tot_next = {8'd0, b};
                    16'd3:
                    begin
                        tot_next = {b, tot_reg[7:0]};
                        if (tot_next > 16'(MAX_TOTAL_BYTES))
                        begin
                            ended = 1'b1;
                            r0.status_code = ucdp_pkg::ST_TOO_LONG;
                        end
                    end
                    16'd4: decl_next = b;
                    16'd8:
                    begin
                        if (tot_reg <= 16'd10)
                        begin
                            ended = 1'b1;
                        end
                        else
                        begin
                            phase_next = ucdp_pkg::PH_WALK;
                            off_next = 8'd0;
                        end
                    end
                    default: ;
                endcase
                if (ended)
                begin
                    n = 2'd1;
                end
            end
            else if (off_reg == 8'd0 && b == 8'd0)
            begin
                ended = 1'b1;
                n = 2'd1;
            end
            else
            begin
                dlen_next = dl_e;
                dtype_next = dt_e;
                fb2_next = f2_e;
                fb3_next = f3_e;
                fb4_next = f4_e;
                fb5_next = f5_e;
                fin = ({1'b0, off_reg} + 9'd1 >= {1'b0, dl_e})
                      || ({1'b0, bi_next} + 17'd1 >= {1'b0, tot_reg});
                nxt = 18'(bi_next) - 18'(off_reg) + 18'(dl_e);
                off_next = off_reg + 8'd1;
                if (fin)
                begin
                    off_next = 8'd0;
                    if (dt_e == ucdp_pkg::DT_INTERFACE)
                    begin
                        if (!cur_val_reg || f2_e != cur_num_reg)
                        begin
                            if (icnt_reg >= IFC_W'(MAX_IFACES))
                            begin
                                ended = 1'b1;
                                r0.status_code = ucdp_pkg::ST_OVERFLOW;
                                n = 2'd1;
                            end
                            else
                            begin
                                cur_eps_next = f4_e;
                                cur_epc_next = '0;
                                icnt_next = icnt_reg + IFC_W'(1);
                                cur_num_next = f2_e;
                                cur_val_next = 1'b1;
                            end
                        end
                    end
                    else if (dt_e == ucdp_pkg::DT_ENDPOINT)
                    begin
                        if (icnt_reg == '0)
                        begin
                            ended = 1'b1;
                            r0.status_code = ucdp_pkg::ST_NO_IFACE;
                            n = 2'd1;
                        end
                        else if (cur_epc_reg >= EPC_W'(MAX_EPS_PER_IFACE))
                        begin
                            ended = 1'b1;
                            r0.status_code = ucdp_pkg::ST_OVERFLOW;
                            n = 2'd1;
                        end
                        else
                        begin
                            cur_epc_next = cur_epc_reg + EPC_W'(1);
                            tin_new = tin_reg[tnum];
                            tout_new = tout_reg[tnum];
                            if (8'(ifno) < decl_reg && 8'(cur_epc_reg) < cur_eps_reg)
                            begin
                                tbl_we = 1'b1;
                                if (f3_e[1:0] == ucdp_pkg::XFER_CONTROL)
                                begin
                                    tin_new = wmp;
                                    tout_new = wmp;
                                end
                                else if ((f2_e & ucdp_pkg::DIR_IN_MASK) != 8'd0)
                                begin
                                    if (wmp > tin_new)
                                    begin
                                        tin_new = wmp;
                                    end
                                end
                                else if (wmp > tout_new)
                                begin
                                    tout_new = wmp;
                                end
                            end
                            r0.record_kind = ucdp_pkg::KIND_EP;
                            r0.iface_slot = 4'(ifno);
                            r0.ep_slot = 5'(cur_epc_reg);
                            r0.ep_number = tnum;
                            r0.ep_is_in = f2_e[7];
                            r0.xfer_kind = f3_e[1:0];
                            r0.packet_limit = wmp;
                            r0.table_in_now = tin_new;
                            r0.table_out_now = tout_new;
                            n = 2'd1;
                        end
                    end
                    if (!ended && nxt + 18'd1 >= 18'(tot_reg))
                    begin
                        ended = 1'b1;
                        if (n == 2'd0)
                        begin
                            r0.iface_total = 5'(icnt_next);
                            n = 2'd1;
                        end
                        else
                        begin
                            r1.record_kind = ucdp_pkg::KIND_END;
                            r1.iface_total = 5'(icnt_next);
                            n = 2'd2;
                        end
                    end
                end
            end
            if (ended)
            begin
                phase_next = ucdp_pkg::PH_IDLE;
            end
            if (n == 2'd2)
            begin
                r1.run_last = 1'b1;
            end
            else
            begin
                r0.run_last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ucdp_pkg::PH_IDLE;
            bi_reg <= 16'd0;
            tot_reg <= 16'd0;
            off_reg <= 8'd0;
            dlen_reg <= 8'd0;
            dtype_reg <= 8'd0;
            fb2_reg <= 8'd0;
            fb3_reg <= 8'd0;
            fb4_reg <= 8'd0;
            fb5_reg <= 8'd0;
            decl_reg <= 8'd0;
            icnt_reg <= '0;
            cur_num_reg <= 8'd0;
            cur_val_reg <= 1'b0;
            cur_eps_reg <= 8'd0;
            cur_epc_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            bi_reg <= bi_next;
            tot_reg <= tot_next;
            off_reg <= off_next;
            dlen_reg <= dlen_next;
            dtype_reg <= dtype_next;
            fb2_reg <= fb2_next;
            fb3_reg <= fb3_next;
            fb4_reg <= fb4_next;
            fb5_reg <= fb5_next;
            decl_reg <= decl_next;
            icnt_reg <= icnt_next;
            cur_num_reg <= cur_num_next;
            cur_val_reg <= cur_val_next;
            cur_eps_reg <= cur_eps_next;
            cur_epc_reg <= cur_epc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_EP; i++)
            begin
                tin_reg[i] <= (i == 0) ? 16'd64 : 16'd0;
                tout_reg[i] <= (i == 0) ? 16'd64 : 16'd0;
            end
        end
        else if (tbl_clr)
        begin
            for (int i = 0; i < NUM_EP; i++)
            begin
                tin_reg[i] <= (i == 0) ? {9'd0, ep0_reg} : 16'd0;
                tout_reg[i] <= (i == 0) ? {9'd0, ep0_reg} : 16'd0;
            end
        end
        else if (tbl_we)
        begin
            tin_reg[tnum] <= tin_new;
            tout_reg[tnum] <= tout_new;
        end
    end

    // output queue
    assign pop = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk)
    begin
        if (n != 2'd0)
        begin
            fifo_reg[wr_reg] <= r0;
        end
        if (n == 2'd2)
        begin
            fifo_reg[wr_reg + PTR_W'(1)] <= r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_reg + PTR_W'(n);
            rd_reg <= rd_reg + PTR_W'(pop);
            cnt_reg <= cnt_reg + CNT_W'(n) - CNT_W'(pop);
        end
    end

    assign out_ch.valid = (cnt_reg != '0);
    assign out_ch.record_kind = fifo_reg[rd_reg].record_kind;
    assign out_ch.iface_slot = fifo_reg[rd_reg].iface_slot;
    assign out_ch.ep_slot = fifo_reg[rd_reg].ep_slot;
    assign out_ch.ep_number = fifo_reg[rd_reg].ep_number;
    assign out_ch.ep_is_in = fifo_reg[rd_reg].ep_is_in;
    assign out_ch.xfer_kind = fifo_reg[rd_reg].xfer_kind;
    assign out_ch.packet_limit = fifo_reg[rd_reg].packet_limit;
    assign out_ch.table_in_now = fifo_reg[rd_reg].table_in_now;
    assign out_ch.table_out_now = fifo_reg[rd_reg].table_out_now;
    assign out_ch.iface_total = fifo_reg[rd_reg].iface_total;
    assign out_ch.status_code = fifo_reg[rd_reg].status_code;
    assign out_ch.run_last = fifo_reg[rd_reg].run_last;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("output queue overfilled");

    a_push_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
        n != 2'd0 |-> acc && !in_ch.start_flag)
        else $error("record without accepted byte");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        n == 2'd2 |-> r0.record_kind == ucdp_pkg::KIND_EP
                      && r1.record_kind == ucdp_pkg::KIND_END && r1.run_last)
        else $error("bad record pair");

    a_end_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (n != 2'd0 && (r0.record_kind == ucdp_pkg::KIND_END || n == 2'd2))
        |=> phase_reg == ucdp_pkg::PH_IDLE)
        else $error("parser busy after end record");

endmodule

/* tb/tb_usb_config_descriptor_parser.sv */
module tb_usb_config_descriptor_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_IFACES        = 16;
    localparam int MAX_EPS_PER_IFACE = 32;
    localparam int MAX_TOTAL_BYTES   = 4096;
    localparam int STALL_LIMIT       = 5000;
    localparam logic [7:0] DT_COMPANION = 8'h30;
    localparam logic [7:0] DT_CLASS     = 8'h24;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ucdp_in_if  in_ch ();
    ucdp_out_if out_ch ();

    usb_config_descriptor_parser u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // parser shadow state
    logic [6:0] ep0_size;
    int         pos;
    int         total_len;
    int         dsc_off;
    int         dsc_len;
    int         dsc_type;
    int         fields [7];
    logic [1:0] phase;
    int         decl_ifaces;
    int         iface_cnt;
    int         cur_iface;
    bit         cur_iface_ok;
    int         iface_decl_eps [MAX_IFACES];
    int         iface_eps [MAX_IFACES];
    int         iface_alts [MAX_IFACES];
    int         max_in [ucdp_pkg::EP_NUMBERS];
    int         max_out [ucdp_pkg::EP_NUMBERS];

    ucdp_pkg::rec_t byte_recs [$];
    ucdp_pkg::rec_t pending_recs [$];
    logic [7:0] cfg_bytes [$];

    int  errors;
    int  stall_cycles;
    bit  no_idle;
    int  rx_hold;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (no_idle || r < 6)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    function automatic void clear_parse();
        pos = 0;
        total_len = 0;
        dsc_off = 0;
        dsc_len = 0;
        dsc_type = 0;
        decl_ifaces = 0;
        iface_cnt = 0;
        cur_iface = 0;
        cur_iface_ok = 1'b0;
        for (int i = 0; i < 7; i++)
            fields[i] = 0;
        for (int i = 0; i < MAX_IFACES; i++)
        begin
            iface_decl_eps[i] = 0;
            iface_eps[i] = 0;
            iface_alts[i] = 0;
        end
        for (int i = 0; i < ucdp_pkg::EP_NUMBERS; i++)
        begin
            max_in[i] = 0;
            max_out[i] = 0;
        end
        max_in[0] = ep0_size;
        max_out[0] = ep0_size;
    endfunction

    function automatic void end_parse(logic [2:0] status);
        ucdp_pkg::rec_t r;
        r = '0;
        r.record_kind = ucdp_pkg::KIND_END;
        r.iface_total = iface_cnt[4:0];
        r.status_code = status;
        byte_recs.push_back(r);
        phase = ucdp_pkg::PH_IDLE;
    endfunction

    // returns 1 when the descriptor ended the parse with an error
    function automatic bit close_descriptor();
        ucdp_pkg::rec_t r;
        int   slot;
        int   epn;
        int   num;
        int   wmp;
        bit   is_in;
        if (dsc_type == ucdp_pkg::DT_INTERFACE)
        begin
            if (!cur_iface_ok || fields[2] != cur_iface)
            begin
                if (iface_cnt >= MAX_IFACES)
                begin
                    end_parse(ucdp_pkg::ST_OVERFLOW);
                    return 1'b1;
                end
                iface_decl_eps[iface_cnt] = fields[4];
                iface_eps[iface_cnt] = 0;
                iface_alts[iface_cnt] = 1;
                iface_cnt++;
                cur_iface = fields[2];
                cur_iface_ok = 1'b1;
            end
            else if (iface_alts[iface_cnt - 1] < 255)
                iface_alts[iface_cnt - 1]++;
        end
        else if (dsc_type == ucdp_pkg::DT_ENDPOINT)
        begin
            if (iface_cnt == 0)
            begin
                end_parse(ucdp_pkg::ST_NO_IFACE);
                return 1'b1;
            end
            slot = iface_cnt - 1;
            epn = iface_eps[slot];
            if (epn >= MAX_EPS_PER_IFACE)
            begin
                end_parse(ucdp_pkg::ST_OVERFLOW);
                return 1'b1;
            end
            iface_eps[slot] = epn + 1;
            num = fields[2] & 15;
            is_in = (fields[2] & ucdp_pkg::DIR_IN_MASK) != 0;
            wmp = fields[4] | (fields[5] << 8);
            if (slot < decl_ifaces && epn < iface_decl_eps[slot])
            begin
                if ((fields[3] & 3) == ucdp_pkg::XFER_CONTROL)
                begin
                    max_in[num] = wmp;
                    max_out[num] = wmp;
                end
                else if (is_in)
                begin
                    if (wmp > max_in[num])
                        max_in[num] = wmp;
                end
                else if (wmp > max_out[num])
                    max_out[num] = wmp;
            end
            r = '0;
            r.record_kind = ucdp_pkg::KIND_EP;
            r.iface_slot = slot[3:0];
            r.ep_slot = epn[4:0];
            r.ep_number = num[3:0];
            r.ep_is_in = is_in;
            r.xfer_kind = fields[3][1:0];
            r.packet_limit = wmp[15:0];
            r.table_in_now = max_in[num][15:0];
            r.table_out_now = max_out[num][15:0];
            r.iface_total = iface_cnt[4:0];
            r.status_code = ucdp_pkg::ST_OK;
            byte_recs.push_back(r);
        end
        return 1'b0;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic st);
        int off;
        int nxt;
        byte_recs.delete();
        if (st)
        begin
            clear_parse();
            phase = ucdp_pkg::PH_HEADER;
            dsc_len = b;
            return;
        end
        if (phase == ucdp_pkg::PH_IDLE)
            return;
        pos = (pos + 1) & 16'hFFFF;
        if (phase == ucdp_pkg::PH_HEADER)
        begin
            case (pos)
                1:
                begin
                    dsc_type = b;
                    if (b != ucdp_pkg::DT_CONFIG)
                        end_parse(ucdp_pkg::ST_NOT_CFG);
                    else if (dsc_len != ucdp_pkg::CFG_HDR_LEN)
                        end_parse(ucdp_pkg::ST_BAD_LEN);
                end
                2: total_len = b;
                3:
                begin
                    total_len = total_len | (b << 8);
                    if (total_len > MAX_TOTAL_BYTES)
                        end_parse(ucdp_pkg::ST_TOO_LONG);
                end
                4: decl_ifaces = b;
                8:
                begin
                    if (total_len <= 10)
                        end_parse(ucdp_pkg::ST_OK);
                    else
                    begin
                        phase = ucdp_pkg::PH_WALK;
                        dsc_off = 0;
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            off = dsc_off;
            if (off == 0 && b == 0)
                end_parse(ucdp_pkg::ST_OK);
            else
            begin
                if (off == 0)
                begin
                    for (int i = 0; i < 7; i++)
                        fields[i] = 0;
                    dsc_len = b;
                    dsc_type = 0;
                end
                if (off < 7)
                    fields[off] = b;
                if (off == 1)
                    dsc_type = b;
                if (off + 1 >= dsc_len || pos + 1 >= total_len)
                begin
                    nxt = (pos - off) + dsc_len;
                    if (!close_descriptor())
                    begin
                        if (nxt + 1 >= total_len)
                            end_parse(ucdp_pkg::ST_OK);
                        else
                            dsc_off = 0;
                    end
                end
                else
                    dsc_off = off + 1;
            end
        end
        for (int k = 0; k < byte_recs.size(); k++)
        begin
            byte_recs[k].run_last = (k == byte_recs.size() - 1);
            pending_recs.push_back(byte_recs[k]);
        end
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        ucdp_pkg::rec_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_recs.size() == 0)
            begin
                $error("record with none pending");
                errors++;
            end
            else
            begin
                e = pending_recs.pop_front();
                check_field("record_kind", e.record_kind, out_ch.record_kind);
                check_field("iface_slot", e.iface_slot, out_ch.iface_slot);
                check_field("ep_slot", e.ep_slot, out_ch.ep_slot);
                check_field("ep_number", e.ep_number, out_ch.ep_number);
                check_field("ep_is_in", e.ep_is_in, out_ch.ep_is_in);
                check_field("xfer_kind", e.xfer_kind, out_ch.xfer_kind);
                check_field("packet_limit", e.packet_limit, out_ch.packet_limit);
                check_field("table_in_now", e.table_in_now, out_ch.table_in_now);
                check_field("table_out_now", e.table_out_now, out_ch.table_out_now);
                check_field("iface_total", e.iface_total, out_ch.iface_total);
                check_field("status_code", e.status_code, out_ch.status_code);
                check_field("run_last", e.run_last, out_ch.run_last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (rx_hold > 0)
        begin
            out_ch.ready <= 1'b0;
            rx_hold--;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
                rx_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n || psel)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[usb_config_descriptor_parser] ERROR");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, logic st);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.start_flag <= st;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_byte(b, st);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_cfg();
        for (int i = 0; i < cfg_bytes.size(); i++)
            send_byte(cfg_bytes[i], i == 0);
    endtask

    task automatic wait_drained();
        while (pending_recs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_ep0(logic [6:0] v);
        in_ch.valid <= 1'b0;
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {ucdp_pkg::REG_EP0_SIZE, 2'b00};
        pwdata <= {25'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        ep0_size = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic void put_header(int nifs);
        cfg_bytes.delete();
        cfg_bytes = '{8'd9, ucdp_pkg::DT_CONFIG, 8'd0, 8'd0, nifs[7:0], 8'd1, 8'd0,
                      8'h80, 8'd50};
    endfunction

    function automatic void set_total(int t);
        cfg_bytes[2] = t[7:0];
        cfg_bytes[3] = t[15:8];
    endfunction

    function automatic void put_iface(int num, int alt, int neps);
        cfg_bytes.push_back(8'd9);
        cfg_bytes.push_back(ucdp_pkg::DT_INTERFACE);
        cfg_bytes.push_back(num[7:0]);
        cfg_bytes.push_back(alt[7:0]);
        cfg_bytes.push_back(neps[7:0]);
        cfg_bytes.push_back(8'hFF);
        cfg_bytes.push_back(8'd0);
        cfg_bytes.push_back(8'd0);
        cfg_bytes.push_back(8'd0);
    endfunction

    function automatic void put_ep(logic [7:0] addr, logic [7:0] attr, logic [15:0] wmp);
        cfg_bytes.push_back(8'd7);
        cfg_bytes.push_back(ucdp_pkg::DT_ENDPOINT);
        cfg_bytes.push_back(addr);
        cfg_bytes.push_back(attr);
        cfg_bytes.push_back(wmp[7:0]);
        cfg_bytes.push_back(wmp[15:8]);
        cfg_bytes.push_back(8'd1);
    endfunction

    function automatic void put_other(logic [7:0] kind, int len);
        cfg_bytes.push_back(len[7:0]);
        cfg_bytes.push_back(kind);
        for (int i = 2; i < len; i++)
            cfg_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic test_header_checks();
        cfg_bytes = '{8'd9, 8'd3, 8'd20, 8'd0};
        send_cfg();
        cfg_bytes = '{8'd255, ucdp_pkg::DT_CONFIG, 8'd20, 8'd0};
        send_cfg();
        put_header(1);
        set_total(MAX_TOTAL_BYTES + 1);
        send_cfg();
        put_header(1);
        set_total(16'hFFFF);
        send_cfg();
        put_header(0);
        set_total(10);
        send_cfg();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_endpoints();
        put_header(2);
        put_iface(0, 0, 3);
        put_ep(8'h81, 8'h02, 16'd512);
        put_ep(8'h01, 8'h03, 16'hFFFF);
        put_ep(8'h00, 8'h00, 16'd0);
        put_iface(0, 1, 1);
        put_iface(5, 0, 1);
        put_ep(8'h8F, 8'h01, 16'd1023);
        put_other(DT_COMPANION, 6);
        put_ep(8'h8F, 8'h03, 16'd2000);
        set_total(cfg_bytes.size());
        send_cfg();
        put_header(1);
        put_ep(8'h82, 8'h02, 16'd64);
        set_total(cfg_bytes.size());
        send_cfg();
        put_header(1);
        put_iface(1, 0, 1);
        put_ep(8'h83, 8'h02, 16'd64);
        set_total(cfg_bytes.size() - 3);
        send_cfg();
        put_header(1);
        put_iface(1, 0, 1);
        cfg_bytes.push_back(8'd0);
        cfg_bytes.push_back(8'd0);
        set_total(40);
        send_cfg();
        put_header(1);
        put_iface(1, 0, 1);
        put_ep(8'h81, 8'h02, 16'd8);
        set_total(60);
        send_cfg();
    endtask

    task automatic test_overflow();
        put_header(20);
        for (int i = 0; i <= MAX_IFACES; i++)
            put_iface(i, 0, 1);
        set_total(cfg_bytes.size());
        send_cfg();
        put_header(1);
        put_iface(0, 0, 40);
        for (int i = 0; i <= MAX_EPS_PER_IFACE; i++)
            put_ep(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom()));
        set_total(cfg_bytes.size());
        send_cfg();
    endtask

    task automatic random_cfg();
        int nifs;
        int neps;
        int num;
        int t;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            cfg_bytes.delete();
            for (int i = 0; i < $urandom_range(1, 12); i++)
                cfg_bytes.push_back(8'($urandom_range(0, 255)));
            send_cfg();
            return;
        end
        nifs = $urandom_range(0, 4);
        put_header($urandom_range(0, 5));
        num = $urandom_range(0, 255);
        for (int i = 0; i < nifs; i++)
        begin
            if ($urandom_range(0, 3) != 0)
                num = $urandom_range(0, 255);
            neps = $urandom_range(0, 4);
            put_iface(num, $urandom_range(0, 3), $urandom_range(0, 5));
            for (int j = 0; j < neps; j++)
            begin
                if ($urandom_range(0, 7) == 0)
                    put_other($urandom_range(0, 1) ? DT_COMPANION : DT_CLASS,
                              $urandom_range(2, 9));
                put_ep(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 1) ? $urandom_range(0, 1024) : $urandom()));
            end
        end
        if (sel == 1)
            put_ep(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom()));
        t = cfg_bytes.size();
        if (sel == 2)
            t = $urandom_range(9, t);
        else if (sel == 3)
            t = t + $urandom_range(1, 10);
        else if (sel == 4)
            cfg_bytes.push_back(8'd0);
        else if (sel == 5)
            cfg_bytes = cfg_bytes[0:$urandom_range(1, cfg_bytes.size() - 1)];
        set_total(t);
        send_cfg();
        if ($urandom_range(0, 5) == 0)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_random(int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            no_idle = ($urandom_range(0, 7) == 0);
            random_cfg();
            sent += cfg_bytes.size();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        logic [6:0] sizes [5];
        errors = 0;
        stall_cycles = 0;
        no_idle = 1'b0;
        rx_hold = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.start_flag = 1'b0;
        ep0_size = 7'd64;
        clear_parse();
        phase = ucdp_pkg::PH_IDLE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_checks();
        test_endpoints();
        test_overflow();
        sizes = '{7'd8, 7'd64, 7'd0, 7'd127, 7'd0};
        sizes[4] = 7'($urandom_range(8, 64));
        foreach (sizes[i])
        begin
            write_ep0(sizes[i]);
            test_random(90);
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_recs.size() == 0)
            $display("[usb_config_descriptor_parser] OK");
        else
            $display("[usb_config_descriptor_parser] ERROR");
        $finish;
    end

endmodule
